### sv/hbk_pkg.sv
`timescale 1ns / 1ps
// Package for the HID boot keyboard report decoder.
// Holds sizes, the queue entry type and the usage-to-keycode table; no dependencies.
package hbk_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int MOD_COUNT = 8;
    localparam int ROM_SIZE  = 252;
    localparam int EVT_COUNT = MOD_COUNT + 2 * KEY_SLOTS;
    localparam int EVT_W     = $clog2(EVT_COUNT);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam logic [7:0] MOD_BASE = 8'd224;

    typedef struct packed {
        logic [EVT_COUNT-1:0]           mask;
        logic [MOD_COUNT-1:0]           mods;
        logic [KEY_SLOTS-1:0][7:0]      old_keys;
        logic [KEY_SLOTS-1:0][7:0]      new_keys;
    } t_entry;

    localparam logic [7:0] USAGE_ROM [0:ROM_SIZE-1] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd30,  8'd48,  8'd46,  8'd32,
        8'd18,  8'd33,  8'd34,  8'd35,  8'd23,  8'd36,  8'd37,  8'd38,
        8'd50,  8'd49,  8'd24,  8'd25,  8'd16,  8'd19,  8'd31,  8'd20,
        8'd22,  8'd47,  8'd17,  8'd45,  8'd21,  8'd44,  8'd2,   8'd3,
        8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,
        8'd28,  8'd1,   8'd14,  8'd15,  8'd57,  8'd12,  8'd13,  8'd26,
        8'd27,  8'd43,  8'd43,  8'd39,  8'd40,  8'd41,  8'd51,  8'd52,
        8'd53,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,
        8'd65,  8'd66,  8'd67,  8'd68,  8'd87,  8'd88,  8'd99,  8'd70,
        8'd119, 8'd110, 8'd102, 8'd104, 8'd111, 8'd107, 8'd109, 8'd106,
        8'd105, 8'd108, 8'd103, 8'd69,  8'd98,  8'd55,  8'd74,  8'd78,
        8'd96,  8'd79,  8'd80,  8'd81,  8'd75,  8'd76,  8'd77,  8'd71,
        8'd72,  8'd73,  8'd82,  8'd83,  8'd86,  8'd127, 8'd116, 8'd117,
        8'd183, 8'd184, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd190,
        8'd191, 8'd192, 8'd193, 8'd194, 8'd134, 8'd138, 8'd130, 8'd132,
        8'd128, 8'd129, 8'd131, 8'd137, 8'd133, 8'd135, 8'd136, 8'd113,
        8'd115, 8'd114, 8'd0,   8'd0,   8'd0,   8'd121, 8'd0,   8'd89,
        8'd93,  8'd124, 8'd92,  8'd94,  8'd95,  8'd0,   8'd0,   8'd0,
        8'd122, 8'd123, 8'd90,  8'd91,  8'd85,  8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd29,  8'd42,  8'd56,  8'd125, 8'd97,  8'd54,  8'd100, 8'd126,
        8'd164, 8'd166, 8'd165, 8'd163, 8'd161, 8'd115, 8'd114, 8'd113,
        8'd150, 8'd158, 8'd159, 8'd128, 8'd136, 8'd177, 8'd178, 8'd176,
        8'd142, 8'd152, 8'd173, 8'd140
    };

    function automatic logic [7:0] lookup(input logic [7:0] usage);
        logic [7:0] code;
        code = 8'd0;
        if (usage < 8'(ROM_SIZE)) begin
            code = USAGE_ROM[usage];
        end
        return code;
    endfunction

endpackage

### sv/hid_boot_keyboard_report_to_key_events_unit.sv
`timescale 1ns / 1ps
// Each report that differs from the previous one yields one key event per changed
// modifier bit and per slot change (release of the old usage if nonzero, then press of
// the new one if nonzero), at one event per cycle while the output is not stalled; the
// events come from the event walker in the back end. Reports that change nothing give
// no transaction. A two-entry queue lets new reports be taken while events are still
// going out. Top level; uses hbk_pkg, hbk_front, hbk_queue and hbk_back.
module hid_boot_keyboard_report_to_key_events_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // modifier_bits [7:0], key_slot_0 .. key_slot_5 in the following bytes
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // key_code [7:0], pressed [8], zero [15:9]
    output logic [15:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    logic            push;
    logic            pop;
    logic            q_space;
    logic            q_valid;
    hbk_pkg::t_entry push_entry;
    hbk_pkg::t_entry head_entry;
    logic [7:0]      key_code;
    logic            pressed;

    hbk_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .i_space (q_space),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_entry (push_entry)
    );

    hbk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_space (q_space),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    hbk_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_entry  (head_entry),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_key_code (key_code),
        .o_pressed  (pressed),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {7'd0, pressed, key_code};

endmodule

### sv/hbk_front.sv
`timescale 1ns / 1ps
// Front end of the HID boot keyboard report decoder: holds the previous report,
// compares each new report with it and queues a change mask. Uses hbk_pkg.
module hbk_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [55:0]    i_data,
    input  logic           i_space,
    output logic           o_ready,
    output logic           o_push,
    output hbk_pkg::t_entry o_entry
);

    logic [hbk_pkg::MOD_COUNT-1:0]          r_prev_mods;
    logic [hbk_pkg::KEY_SLOTS-1:0][7:0]     r_prev_keys;
    logic                                   accept;
    hbk_pkg::t_entry                        entry;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    always_comb begin
        entry          = '0;
        entry.mods     = i_data[hbk_pkg::MOD_COUNT-1:0];
        entry.old_keys = r_prev_keys;
        for (int m = 0; m < hbk_pkg::MOD_COUNT; m++) begin
            entry.mask[m] = i_data[m] ^ r_prev_mods[m];
        end
        for (int s = 0; s < hbk_pkg::KEY_SLOTS; s++) begin
            entry.new_keys[s] = i_data[8*(s+1) +: 8];
            entry.mask[hbk_pkg::MOD_COUNT + 2*s] =
                (entry.new_keys[s] != r_prev_keys[s]) && (r_prev_keys[s] != 8'd0);
            entry.mask[hbk_pkg::MOD_COUNT + 2*s + 1] =
                (entry.new_keys[s] != r_prev_keys[s]) && (entry.new_keys[s] != 8'd0);
        end
    end

    assign o_entry = entry;
    assign o_push  = accept && (entry.mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mods <= '0;
            r_prev_keys <= '0;
        end else if (accept) begin
            r_prev_mods <= entry.mods;
            r_prev_keys <= entry.new_keys;
        end
    end

endmodule

### sv/hbk_queue.sv
`timescale 1ns / 1ps
// Short queue between the front and back ends of the report decoder.
// Stores hbk_pkg::t_entry words; depends on hbk_pkg.
module hbk_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hbk_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_space,
    output logic            o_valid,
    output hbk_pkg::t_entry o_entry
);

    hbk_pkg::t_entry                r_mem [hbk_pkg::QDEPTH];
    logic [hbk_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [hbk_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [hbk_pkg::QCNT_W-1:0]     r_count;
    logic [hbk_pkg::QCNT_W-1:0]     n_count;
    logic                           do_pop;

    assign o_space = (r_count != hbk_pkg::QCNT_W'(hbk_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == hbk_pkg::QPTR_W'(hbk_pkg::QDEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == hbk_pkg::QPTR_W'(hbk_pkg::QDEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

### sv/hbk_back.sv
`timescale 1ns / 1ps
// Back end of the report decoder: walks the change mask of one queued entry and emits one
// key event per cycle, while the output is not stalled, through an output register. Uses hbk_pkg.
module hbk_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  hbk_pkg::t_entry i_q_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_key_code,
    output logic            o_pressed,
    output logic            o_last
);

    hbk_pkg::t_entry                r_work;
    logic                           r_busy;
    logic                           r_out_valid;
    logic [7:0]                     r_key_code;
    logic                           r_pressed;
    logic                           r_last;
    logic                           adv;
    logic                           fire;
    logic                           finish;
    logic                           load;
    logic [hbk_pkg::EVT_W-1:0]      idx;
    logic [hbk_pkg::EVT_W-1:0]      rel;
    logic [hbk_pkg::EVT_COUNT-1:0]  rest;
    logic [7:0]                     usage;
    logic                           level;

    assign adv    = !r_out_valid || i_ready;
    assign fire   = r_busy && adv;
    assign rest   = r_work.mask & (r_work.mask - 1'b1);
    assign finish = fire && (rest == '0);
    assign load   = (!r_busy || finish) && i_q_valid;
    assign o_pop  = load;

    always_comb begin
        idx = '0;
        for (int e = hbk_pkg::EVT_COUNT - 1; e >= 0; e--) begin
            if (r_work.mask[e]) begin
                idx = hbk_pkg::EVT_W'(e);
            end
        end
    end

    always_comb begin
        rel   = idx - hbk_pkg::EVT_W'(hbk_pkg::MOD_COUNT);
        usage = hbk_pkg::MOD_BASE + 8'(idx);
        level = r_work.mods[idx[2:0]];
        if (idx >= hbk_pkg::EVT_W'(hbk_pkg::MOD_COUNT)) begin
            usage = 8'd0;
            level = rel[0];
            for (int s = 0; s < hbk_pkg::KEY_SLOTS; s++) begin
                if (rel[hbk_pkg::EVT_W-1:1] == (hbk_pkg::EVT_W-1)'(s)) begin
                    usage = rel[0] ? r_work.new_keys[s] : r_work.old_keys[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_work <= i_q_entry;
        end else if (fire) begin
            r_work.mask <= rest;
        end
        if (fire) begin
            r_key_code <= hbk_pkg::lookup(usage);
            r_pressed  <= level;
            r_last     <= (rest == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_key_code = r_key_code;
    assign o_pressed  = r_pressed;
    assign o_last     = r_last;

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_work.mask != '0))
        else $error("Busy back end holds an empty change mask.");

    a_fire_gives_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("Event was issued but the output register is not valid.");

    a_load_while_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_busy || finish))
        else $error("New entry loaded while the current one is unfinished.");

endmodule

### verif/tb_hid_boot_keyboard_report_to_key_events_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the HID boot keyboard report decoder: a queue-fed stream driver,
// an event monitor and a predictor that holds its own copy of the previous report.
// Depends on hbk_pkg for sizes and the usage table, and on the decoder top level.
module tb_hid_boot_keyboard_report_to_key_events_unit;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int REPORT_TARGET  = 500;
    localparam int CALM_START     = 1000;
    localparam int CALM_END       = 2000;

    typedef struct packed {
        logic [5:0][7:0] slots;
        logic [7:0]      mods;
    } t_report;

    typedef struct packed {
        logic [7:0] code;
        logic       down;
        logic       is_last;
    } t_key_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // modifier_bits [7:0], key_slot_0 .. key_slot_5 in the following bytes
    logic [55:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // key_code [7:0], pressed [8], zero [15:9]
    logic [15:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    t_report     pending_reports[$];
    t_key_event  expected_events[$];
    logic [7:0]  held_mods = '0;
    logic [7:0]  held_slots[hbk_pkg::KEY_SLOTS];
    int          error_count = 0;
    int          cycle_count = 0;
    int          quiet_cycles = 0;

    hid_boot_keyboard_report_to_key_events_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [7:0] usage_to_code(input logic [7:0] usage);
        if (int'(usage) >= hbk_pkg::ROM_SIZE) begin
            return 8'd0;
        end
        return hbk_pkg::USAGE_ROM[usage];
    endfunction

    function automatic logic [7:0] pick_usage();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return 8'd0;
        end else if (r < 18) begin
            return 8'(252 + $urandom_range(3));
        end else if (r < 25) begin
            return 8'($urandom);
        end
        return 8'($urandom_range(1, 251));
    endfunction

    function automatic logic in_calm_window(input int cyc);
        return (cyc >= CALM_START) && (cyc < CALM_END);
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic derive_key_events(input t_report rpt);
        t_key_event found[$];
        t_key_event ev;
        for (int i = 0; i < hbk_pkg::MOD_COUNT; i++) begin
            if (rpt.mods[i] != held_mods[i]) begin
                ev.code    = usage_to_code(8'(hbk_pkg::MOD_BASE + i));
                ev.down    = rpt.mods[i];
                ev.is_last = 1'b0;
                found.push_back(ev);
            end
        end
        for (int i = 0; i < hbk_pkg::KEY_SLOTS; i++) begin
            if (rpt.slots[i] != held_slots[i]) begin
                if (held_slots[i] != 8'd0) begin
                    ev.code    = usage_to_code(held_slots[i]);
                    ev.down    = 1'b0;
                    ev.is_last = 1'b0;
                    found.push_back(ev);
                end
                if (rpt.slots[i] != 8'd0) begin
                    ev.code    = usage_to_code(rpt.slots[i]);
                    ev.down    = 1'b1;
                    ev.is_last = 1'b0;
                    found.push_back(ev);
                end
            end
            held_slots[i] = rpt.slots[i];
        end
        held_mods = rpt.mods;
        if (found.size() > 0) begin
            found[found.size() - 1].is_last = 1'b1;
        end
        foreach (found[k]) begin
            expected_events.push_back(found[k]);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                derive_key_events(t_report'(i_s_axis_tdata));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_reports.size() > 0 &&
                        (in_calm_window(cycle_count) || $urandom_range(99) >= 34)) begin
                    i_s_axis_tdata  <= pending_reports.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_key_event want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_events.size() == 0) begin
                    note_failure($sformatf("Unexpected event: code %0d pressed %0b last %0b",
                        o_m_axis_tdata[7:0], o_m_axis_tdata[8], o_m_axis_tlast));
                end else begin
                    want = expected_events.pop_front();
                    if (o_m_axis_tdata[7:0] !== want.code || o_m_axis_tdata[8] !== want.down ||
                            o_m_axis_tdata[15:9] !== 7'd0 || o_m_axis_tlast !== want.is_last) begin
                        note_failure($sformatf(
                            {"Event mismatch: expected code %0d pressed %0b last %0b, ",
                             "got code %0d pressed %0b pad %0h last %0b"},
                            want.code, want.down, want.is_last, o_m_axis_tdata[7:0],
                            o_m_axis_tdata[8], o_m_axis_tdata[15:9], o_m_axis_tlast));
                    end
                end
            end
            i_m_axis_tready <= in_calm_window(cycle_count) || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_report cur;
        t_report nxt;
        int r;
        int n;
        int b;
        foreach (held_slots[i]) begin
            held_slots[i] = 8'd0;
        end

        // Directed reports: no change, every modifier both ways, each slot transition,
        // the out-of-range and unmapped usages, and a report with the most events.
        cur = '0;
        pending_reports.push_back(cur);
        cur.mods = 8'hFF;
        pending_reports.push_back(cur);
        cur.mods = 8'h00;
        pending_reports.push_back(cur);
        cur.mods = 8'hA5;
        cur.slots[0] = 8'd4;
        pending_reports.push_back(cur);
        cur.slots[0] = 8'd5;
        cur.slots[1] = 8'd255;
        pending_reports.push_back(cur);
        cur.slots = {8'd224, 8'd251, 8'd255, 8'd254, 8'd253, 8'd252};
        pending_reports.push_back(cur);
        cur.slots = {8'd1, 8'd130, 8'd144, 8'd231, 8'd128, 8'd3};
        pending_reports.push_back(cur);
        cur.slots = '0;
        pending_reports.push_back(cur);
        cur.mods = 8'h00;
        cur.slots = {8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'hE7};
        pending_reports.push_back(cur);
        cur.mods = 8'hFF;
        cur.slots = {8'hFE, 8'h7F, 8'h80, 8'h55, 8'hAA, 8'h18};
        pending_reports.push_back(cur);
        pending_reports.push_back(cur);
        cur.mods = 8'h5A;
        cur.slots[2] = 8'd0;
        cur.slots[4] = 8'd0;
        pending_reports.push_back(cur);
        cur = '0;
        pending_reports.push_back(cur);

        // Random reports: mostly small edits of the previous one, as a real keyboard sends.
        while (pending_reports.size() < REPORT_TARGET) begin
            nxt = cur;
            r = $urandom_range(99);
            if (r < 15) begin
                nxt.mods = 8'($urandom);
                for (int i = 0; i < 6; i++) begin
                    nxt.slots[i] = 8'($urandom);
                end
            end else if (r < 25) begin
                nxt = cur;
            end else if (r < 40) begin
                nxt.mods = nxt.mods & 8'($urandom);
                for (int i = 0; i < 6; i++) begin
                    if ($urandom_range(1) == 1) begin
                        nxt.slots[i] = 8'd0;
                    end
                end
            end else begin
                if ($urandom_range(1) == 1) begin
                    b = $urandom_range(7);
                    nxt.mods[b] = ~nxt.mods[b];
                end
                n = $urandom_range(1, 2);
                for (int k = 0; k < n; k++) begin
                    nxt.slots[$urandom_range(5)] = pick_usage();
                end
            end
            pending_reports.push_back(nxt);
            cur = nxt;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_reports.size() != 0 || i_s_axis_tvalid) begin
            @(negedge i_clk);
        end
        while (expected_events.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_events.size() != 0) begin
            note_failure($sformatf("%0d expected events never arrived",
                expected_events.size()));
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
sv/hbk_pkg.sv
sv/hbk_front.sv
sv/hbk_queue.sv
sv/hbk_back.sv
sv/hid_boot_keyboard_report_to_key_events_unit.sv
verif/tb_hid_boot_keyboard_report_to_key_events_unit.sv
